@@ rtl/core/astd_pkg.sv @@
// Shared types and constants for the audio silence trim detector.
// No dependencies; the top level refers to everything here by scoped name.
package astd_pkg;

  // Channels the block can examine per frame
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 16;
  localparam int RATE_BITS   = 18;
  localparam int MSDUR_BITS  = 16;
  localparam int CHAN_BITS   = 2;
  localparam int MS_BITS     = 37;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [LEVEL_BITS-1:0] SILENCE_RESET   = 16'd33;
  localparam logic [LEVEL_BITS-1:0] AMBIGUITY_RESET = 16'd328;
  localparam logic [RATE_BITS-1:0]  RATE_RESET      = 18'd44100;
  localparam logic [MSDUR_BITS-1:0] MSDUR_RESET     = 16'd0;
  localparam logic [CHAN_BITS-1:0]  CHAN_RESET      = 2'd2;

  localparam logic [MS_BITS-1:0] MS_MAX = {MS_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SILENCE   = 3'd0,
    REG_AMBIGUITY = 3'd1,
    REG_RATE      = 3'd2,
    REG_MIN_MS    = 3'd3,
    REG_CHANNELS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

endpackage

@@ rtl/core/audio_silence_trim_detector.sv @@
// Audio silence trim detector: per-frame loudness tracking and a shared
// bit-serial divider that turns silent spans into milliseconds.
// Depends on astd_pkg.
//
// Frames: audio frames may follow back to back while the sequencer is idle;
// none are taken during a finish. A finish item runs each span through the
// shared restoring divider (one quotient bit per cycle), two spans when a loud
// frame was seen, one otherwise; with zero sample rate the divider is skipped.
// Reset (rst, synchronous) restores register defaults and clears the track
// counters and any pending result.
module audio_silence_trim_detector #(
  parameter int COUNT_BITS = 40
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [astd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [astd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic signed [astd_pkg::SAMPLE_BITS-1:0] sample_left,
  input  logic signed [astd_pkg::SAMPLE_BITS-1:0] sample_right,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [astd_pkg::MS_BITS-1:0]         leading_ms,
  output logic [astd_pkg::MS_BITS-1:0]         trailing_ms,
  output logic                                 ambiguous
);

  // dividend holds frames*1000, i.e. ten more bits than a frame count
  localparam int DW = COUNT_BITS + 10;
  localparam int CW = $clog2(DW);
  localparam int QW = (DW > astd_pkg::MS_BITS) ? DW : astd_pkg::MS_BITS;
  localparam int RB = astd_pkg::RATE_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [astd_pkg::LEVEL_BITS-1:0] silence_level;
  logic [astd_pkg::LEVEL_BITS-1:0] ambiguity_level;
  logic [RB-1:0]                   sample_rate;
  logic [astd_pkg::MSDUR_BITS-1:0] min_duration_ms;
  logic [astd_pkg::CHAN_BITS-1:0]  channels_in_use;

  // track state
  logic [COUNT_BITS-1:0] frame_count;
  logic                  loud_seen;
  logic [COUNT_BITS-1:0] first_loud_frame;
  logic [COUNT_BITS-1:0] last_loud_frame;
  logic [COUNT_BITS-1:0] quiet_loud_count;

  // finish sequencer and divider
  astd_pkg::state_t state, state_next;
  logic                  span_sel;
  logic                  all_silent;
  logic [COUNT_BITS-1:0] span_a;
  logic [COUNT_BITS-1:0] span_b;
  logic [DW-1:0]         quot;
  logic [RB-1:0]         rem;
  logic [CW-1:0]         div_cnt;
  logic [astd_pkg::MS_BITS-1:0] res_lead;
  logic [astd_pkg::MS_BITS-1:0] res_trail;
  logic                  res_amb;

  // combinational helpers
  logic                  in_xfer;
  logic                  load_out;
  logic [16:0]           mag_left;
  logic [16:0]           mag_right;
  logic [16:0]           peak;
  logic                  two_ch;
  logic                  is_loud;
  logic [COUNT_BITS-1:0] span_cur;
  logic [DW-1:0]         span_wide;
  logic [DW-1:0]         dividend;
  logic [RB:0]           rem_sh;
  logic                  rem_ge;
  logic [QW-1:0]         quot_ext;
  logic [astd_pkg::MS_BITS-1:0] ms_val;
  logic [astd_pkg::MS_BITS-1:0] ms_gated;
  logic [COUNT_BITS-1:0] tail_frames;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid & in_ready;

  // full-scale negative sample has magnitude 0x8000
  assign mag_left  = sample_left[15]  ? (17'h10000 - {1'b0, sample_left})
                                      : {1'b0, sample_left};
  assign mag_right = sample_right[15] ? (17'h10000 - {1'b0, sample_right})
                                      : {1'b0, sample_right};
  assign two_ch    = (channels_in_use >= 2'd2) && (astd_pkg::CHANNELS >= 2);
  assign peak      = (two_ch && (mag_right > mag_left)) ? mag_right : mag_left;
  assign is_loud   = peak > {1'b0, silence_level};

  assign tail_frames = (last_loud_frame < frame_count)
                       ? (frame_count - COUNT_BITS'(1) - last_loud_frame)
                       : '0;

  // x1000 = x1024 - x16 - x8
  assign span_cur  = span_sel ? span_b : span_a;
  assign span_wide = DW'(span_cur);
  assign dividend  = (span_wide << 10) - (span_wide << 4) - (span_wide << 3);

  assign rem_sh = {rem, quot[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, sample_rate};

  assign quot_ext = QW'(quot);
  assign ms_val   = (|(quot_ext >> astd_pkg::MS_BITS)) ? astd_pkg::MS_MAX
                                                       : quot_ext[astd_pkg::MS_BITS-1:0];
  // an all-silent track reports its whole length with no minimum gate
  assign ms_gated = (all_silent || (ms_val >= astd_pkg::MS_BITS'(min_duration_ms)))
                    ? ms_val : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= astd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      astd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && mode) begin
          state_next = (sample_rate == '0) ? astd_pkg::ST_OUT : astd_pkg::ST_LOAD;
        end
      end
      astd_pkg::ST_LOAD: begin
        state_next = astd_pkg::ST_DIV;
      end
      astd_pkg::ST_DIV: begin
        if (div_cnt == CW'(DW - 1)) begin
          state_next = astd_pkg::ST_STORE;
        end
      end
      astd_pkg::ST_STORE: begin
        state_next = (span_sel || all_silent) ? astd_pkg::ST_OUT : astd_pkg::ST_LOAD;
      end
      astd_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = astd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = astd_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_level   <= astd_pkg::SILENCE_RESET;
      ambiguity_level <= astd_pkg::AMBIGUITY_RESET;
      sample_rate     <= astd_pkg::RATE_RESET;
      min_duration_ms <= astd_pkg::MSDUR_RESET;
      channels_in_use <= astd_pkg::CHAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        astd_pkg::REG_SILENCE:   silence_level   <= cfg_data[astd_pkg::LEVEL_BITS-1:0];
        astd_pkg::REG_AMBIGUITY: ambiguity_level <= cfg_data[astd_pkg::LEVEL_BITS-1:0];
        astd_pkg::REG_RATE:      sample_rate     <= cfg_data[RB-1:0];
        astd_pkg::REG_MIN_MS:    min_duration_ms <= cfg_data[astd_pkg::MSDUR_BITS-1:0];
        astd_pkg::REG_CHANNELS:  channels_in_use <= cfg_data[astd_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // track counters: update on frames, clear on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= '0;
      loud_seen        <= 1'b0;
      first_loud_frame <= '0;
      last_loud_frame  <= '0;
      quiet_loud_count <= '0;
    end else if (in_xfer) begin
      if (mode) begin
        frame_count      <= '0;
        loud_seen        <= 1'b0;
        first_loud_frame <= '0;
        last_loud_frame  <= '0;
        quiet_loud_count <= '0;
      end else begin
        if (is_loud) begin
          if (!loud_seen) begin
            loud_seen        <= 1'b1;
            first_loud_frame <= frame_count;
          end
          last_loud_frame <= frame_count;
          if ((peak < {1'b0, ambiguity_level}) && (quiet_loud_count != CNT_MAX)) begin
            quiet_loud_count <= quiet_loud_count + COUNT_BITS'(1);
          end
        end
        if (frame_count != CNT_MAX) begin
          frame_count <= frame_count + COUNT_BITS'(1);
        end
      end
    end
  end

  // finish datapath: capture spans, then divide each used span by a nonzero sample rate
  always_ff @(posedge clk) begin
    if (rst) begin
      span_sel <= 1'b0;
      div_cnt  <= '0;
    end else begin
      unique case (state)
        astd_pkg::ST_IDLE: begin
          if (in_xfer && mode) begin
            span_sel   <= 1'b0;
            all_silent <= !loud_seen;
            span_a     <= loud_seen ? first_loud_frame : frame_count;
            span_b     <= tail_frames;
            res_lead   <= '0;
            res_trail  <= '0;
            res_amb    <= loud_seen && (sample_rate != '0) &&
                          (quiet_loud_count > COUNT_BITS'(sample_rate[RB-1:2]));
          end
        end
        astd_pkg::ST_LOAD: begin
          quot    <= dividend;
          rem     <= '0;
          div_cnt <= '0;
        end
        astd_pkg::ST_DIV: begin
          rem     <= rem_ge ? RB'(rem_sh - {1'b0, sample_rate}) : rem_sh[RB-1:0];
          quot    <= {quot[DW-2:0], rem_ge};
          div_cnt <= div_cnt + CW'(1);
        end
        astd_pkg::ST_STORE: begin
          if (span_sel) begin
            res_trail <= ms_gated;
          end else begin
            res_lead <= ms_gated;
          end
          span_sel <= 1'b1;
        end
        astd_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid   <= 1'b1;
      leading_ms  <= res_lead;
      trailing_ms <= res_trail;
      ambiguous   <= res_amb;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode) |=> (frame_count == '0) && !loud_seen)
    else $error("track state not cleared after finish");

  a_quiet_needs_loud: assert property (@(posedge clk) disable iff (rst)
    !loud_seen |-> (quiet_loud_count == '0))
    else $error("quiet count without a loud frame");

  a_loud_order: assert property (@(posedge clk) disable iff (rst)
    loud_seen |-> (last_loud_frame >= first_loud_frame))
    else $error("last loud frame precedes first loud frame");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == astd_pkg::ST_DIV) |-> (div_cnt <= CW'(DW - 1)))
    else $error("divider ran past its bit count");
`endif

endmodule
